// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared codes, widths and item types of the go-back-n link window.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int SEQ_MAX_DEF = 7;
   localparam int WORD_W      = 32;

   // event codes
   localparam logic [2:0] FN_PACKET   = 3'd0;
   localparam logic [2:0] FN_PHY_RDY  = 3'd1;
   localparam logic [2:0] FN_FRAME    = 3'd2;
   localparam logic [2:0] FN_DATA_TMO = 3'd3;
   localparam logic [2:0] FN_ACK_TMO  = 3'd4;

   // result codes
   localparam logic [2:0] ACT_STATUS    = 3'd0;
   localparam logic [2:0] ACT_SEND_DATA = 3'd1;
   localparam logic [2:0] ACT_SEND_ACK  = 3'd2;
   localparam logic [2:0] ACT_DELIVER   = 3'd3;
   localparam logic [2:0] ACT_STOP_TMR  = 3'd4;

   localparam logic KIND_DATA = 1'b0;

   typedef struct packed {
      logic [2:0]        func;
      logic [WORD_W-1:0] packet_word;
      logic              frame_kind;
      logic [2:0]        frame_seq;
      logic [2:0]        frame_ack_no;
      logic              crc_good;
   } req_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        seq_out;
      logic [2:0]        ack_out;
      logic [WORD_W-1:0] payload_out;
      logic              net_enable;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } out_load_type;

endpackage

// File: hw/rtl/gbn_chan_if.sv
// ----------------------------------------------------------------------------
// gbn_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface gbn_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/gbn_out_reg.sv
// ----------------------------------------------------------------------------
// gbn_out_reg
// Result register driving the response channel; frees itself when taken.
// ----------------------------------------------------------------------------
module gbn_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  gbn_pkg::out_load_type load,
   output logic                 free,
   gbn_chan_if.source           rsp_chan
);
   import gbn_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         data_ff <= load.data;
      end
   end

   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = data_ff;
endmodule

// File: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window sequencer: pointers, counts and the walk over the packet store.
// ----------------------------------------------------------------------------
module gbn_ctrl #(
   parameter int SEQ_MAX = gbn_pkg::SEQ_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gbn_pkg::req_type             req_item,
   input  logic                         req_take,
   output logic                         req_open,
   input  logic                         out_free,
   output gbn_pkg::out_load_type        out_load,
   output logic                         ram_wr_en,
   output logic [$clog2(SEQ_MAX+1)-1:0] ram_wr_addr,
   output logic [gbn_pkg::WORD_W-1:0]   ram_wr_data,
   output logic [$clog2(SEQ_MAX+1)-1:0] ram_rd_addr,
   input  logic [gbn_pkg::WORD_W-1:0]   ram_rd_data
);
   import gbn_pkg::*;

   localparam int SW = $clog2(SEQ_MAX + 1);
   localparam int CW = (SW > 3) ? SW : 3;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_ACK    = 3'd2;
   localparam logic [2:0] S_RETX   = 3'd3;
   localparam logic [2:0] S_STATUS = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] nts_ff, nts_in;
   logic [SW-1:0] old_ff, old_in;
   logic [SW-1:0] exp_ff, exp_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic          phy_ff, phy_in;
   req_type       item_ff, item_in;

   logic [2:0]    ack_num;
   logic [CW-1:0] fack_w;
   logic          fack_ok;
   logic          in_win;
   logic          seq_match;
   logic          room;

   function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] v);
      return (v == SW'(SEQ_MAX)) ? '0 : v + SW'(1);
   endfunction

   function automatic logic [SW-1:0] seq_dec(input logic [SW-1:0] v);
      return (v == '0) ? SW'(SEQ_MAX) : v - SW'(1);
   endfunction

   function automatic logic [2:0] to3(input logic [SW-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      return w[2:0];
   endfunction

   function automatic logic in_window(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                      input logic [CW-1:0] c);
      return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
   endfunction

   assign ack_num   = to3(seq_dec(exp_ff));
   assign fack_w    = CW'(item_ff.frame_ack_no);
   assign fack_ok   = fack_w <= CW'(SEQ_MAX);
   assign in_win    = in_window(CW'(old_ff), fack_w, CW'(nts_ff));
   assign seq_match = CW'(item_ff.frame_seq) == CW'(exp_ff);
   assign room      = cnt_ff < SW'(SEQ_MAX);
   assign req_open  = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      nts_in      = nts_ff;
      old_in      = old_ff;
      exp_in      = exp_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      phy_in      = phy_ff;
      item_in     = item_ff;
      out_load    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = nts_ff;
      ram_wr_data = item_ff.packet_word;
      ram_rd_addr = nts_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff.func)
               FN_PACKET: begin
                  if (!room) begin
                     state_in = S_STATUS;
                  end else if (out_free) begin
                     // store the word and send it straight from the item
                     ram_wr_en                 = 1'b1;
                     out_load.valid            = 1'b1;
                     out_load.data.action      = ACT_SEND_DATA;
                     out_load.data.seq_out     = to3(nts_ff);
                     out_load.data.ack_out     = ack_num;
                     out_load.data.payload_out = item_ff.packet_word;
                     cnt_in                    = cnt_ff + SW'(1);
                     nts_in                    = seq_inc(nts_ff);
                     state_in                  = S_STATUS;
                  end
               end
               FN_PHY_RDY: begin
                  phy_in   = 1'b1;
                  state_in = S_STATUS;
               end
               FN_FRAME: begin
                  if (!item_ff.crc_good) begin
                     state_in = S_STATUS;
                  end else if (item_ff.frame_kind == KIND_DATA && seq_match) begin
                     if (out_free) begin
                        out_load.valid            = 1'b1;
                        out_load.data.action      = ACT_DELIVER;
                        out_load.data.seq_out     = item_ff.frame_seq;
                        out_load.data.payload_out = item_ff.packet_word;
                        exp_in                    = seq_inc(exp_ff);
                        state_in                  = S_ACK;
                     end
                  end else begin
                     state_in = S_ACK;
                  end
               end
               FN_DATA_TMO: begin
                  // rewind and prefetch the oldest outstanding word
                  nts_in      = old_ff;
                  ram_rd_addr = old_ff;
                  rem_in      = cnt_ff;
                  state_in    = S_RETX;
               end
               FN_ACK_TMO: begin
                  if (out_free) begin
                     out_load.valid        = 1'b1;
                     out_load.data.action  = ACT_SEND_ACK;
                     out_load.data.ack_out = ack_num;
                     state_in              = S_STATUS;
                  end
               end
               default: begin
                  state_in = S_STATUS;
               end
            endcase
         end
         S_ACK: begin
            if (fack_ok && cnt_ff != '0 && in_win) begin
               if (out_free) begin
                  out_load.valid        = 1'b1;
                  out_load.data.action  = ACT_STOP_TMR;
                  out_load.data.seq_out = to3(old_ff);
                  cnt_in                = cnt_ff - SW'(1);
                  old_in                = seq_inc(old_ff);
               end
            end else begin
               state_in = S_STATUS;
            end
         end
         S_RETX: begin
            if (rem_ff == '0) begin
               state_in = S_STATUS;
            end else if (out_free) begin
               // read data belongs to nts; look ahead one entry
               out_load.valid            = 1'b1;
               out_load.data.action      = ACT_SEND_DATA;
               out_load.data.seq_out     = to3(nts_ff);
               out_load.data.ack_out     = ack_num;
               out_load.data.payload_out = ram_rd_data;
               nts_in                    = seq_inc(nts_ff);
               rem_in                    = rem_ff - SW'(1);
               ram_rd_addr               = seq_inc(nts_ff);
            end
         end
         S_STATUS: begin
            if (out_free) begin
               out_load.valid           = 1'b1;
               out_load.data.action     = ACT_STATUS;
               out_load.data.net_enable = room && phy_ff;
               out_load.data.last       = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nts_ff   <= '0;
         old_ff   <= '0;
         exp_ff   <= '0;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         phy_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nts_ff   <= nts_in;
         old_ff   <= old_in;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         phy_ff   <= phy_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end
endmodule

// File: hw/rtl/go_back_n_link_window.sv
// ----------------------------------------------------------------------------
// go_back_n_link_window
// Go-back-n sender/receiver window engine, one event item in, a run out.
// ----------------------------------------------------------------------------
// req_chan takes one event item: packet offer, phy ready, received frame,
// data timeout or ack timeout. rsp_chan returns the run of result items it
// causes (send data, send ack, deliver, stop timer), always closed by one
// status item with last set that carries net_enable.
// An accepted item is registered, then worked on alone: each result is
// loaded into the output register, which drives rsp_chan, and the next
// result follows only once that register is free. The retransmit walk reads
// the packet store one entry a cycle while the output register is free,
// through its registered read port, fetching one entry ahead.
// req_chan.ready is high only between events; the next event is taken while
// the status item still waits in the output register.
// When rsp_chan stalls the engine holds, nothing is dropped or repeated.
// Reset clears the window pointers, the buffered count and phy ready; the
// packet store is not cleared, and only entries already written are ever
// retransmitted.
// ----------------------------------------------------------------------------
module go_back_n_link_window #(
   parameter int SEQ_MAX = gbn_pkg::SEQ_MAX_DEF
) (
   input  logic     clock,
   input  logic     reset,
   gbn_chan_if.sink   req_chan,
   gbn_chan_if.source rsp_chan
);
   import gbn_pkg::*;

   localparam int SW = $clog2(SEQ_MAX + 1);

   logic              req_take;
   logic              req_open;
   logic              out_free;
   out_load_type      out_load;
   logic              ram_wr_en;
   logic [SW-1:0]     ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [SW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   assign req_chan.ready = req_open;
   assign req_take       = req_chan.valid && req_open;

   gbn_ctrl #(
      .SEQ_MAX(SEQ_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_chan.payload),
      .req_take    (req_take),
      .req_open    (req_open),
      .out_free    (out_free),
      .out_load    (out_load),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   gbn_ram #(
      .WIDTH(WORD_W),
      .DEPTH(SEQ_MAX + 1)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gbn_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   // one event at a time: no item taken in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("event taken while previous event in progress");

   // network enable only travels in the closing status item
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.net_enable |-> rsp_chan.payload.last)
      else $error("net_enable outside status item");

   // last marks the status item and only it
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.last == (rsp_chan.payload.action == ACT_STATUS)))
      else $error("last and status action disagree");
endmodule

// File: sim/tb_go_back_n_link_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_go_back_n_link_window
// Self-checking bench for the go-back-n link window engine: directed event
// sequences cover window fill, drop on a full window, retransmit, in-order and
// out-of-order receive, cumulative acks, bad frames and the timers. Random
// link traffic follows. A behavioral window model in the bench predicts every
// command run, and a checker compares each result item field by field.
// ----------------------------------------------------------------------------
module tb_go_back_n_link_window;

   import gbn_pkg::*;

   localparam int SEQ_MAX     = SEQ_MAX_DEF;
   localparam int SEQ_SPAN    = SEQ_MAX + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 130;

   logic clock;
   logic reset;

   gbn_chan_if #(.payload_type(req_type)) req_if ();
   gbn_chan_if #(.payload_type(rsp_type)) rsp_if ();

   go_back_n_link_window #(.SEQ_MAX(SEQ_MAX)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // window model state
   logic [2:0]  tx_next;
   logic [2:0]  tx_oldest;
   logic [2:0]  rx_expected;
   int unsigned tx_outstanding;
   bit          phy_up;
   logic [31:0] sent_words [0:SEQ_MAX];

   rsp_type pending_cmds[$];

   int unsigned error_count;
   int unsigned cycle_count = 0;
   int unsigned events_sent;
   int unsigned results_checked;
   int unsigned packets_dropped;
   int unsigned frames_delivered;
   int unsigned frames_retired;
   int unsigned frames_resent;
   bit          no_idle;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_cmds.size());
         $display("go_back_n_link_window regression: fail");
         $finish;
      end
   end

   // sink stalls
   always @(negedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 9);
   end

   function automatic logic [2:0] seq_after(input logic [2:0] v);
      return (v >= SEQ_MAX) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic logic [2:0] seq_before(input logic [2:0] v);
      return (v == 3'd0 || v > SEQ_MAX) ? 3'(SEQ_MAX) : v - 3'd1;
   endfunction

   function automatic bit ack_in_window(input logic [2:0] a, input logic [2:0] b,
                                        input logic [2:0] c);
      return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
   endfunction

   function automatic req_type make_event(input logic [2:0] func, input logic [31:0] word,
                                          input logic kind, input logic [2:0] fseq,
                                          input logic [2:0] fack, input logic good);
      req_type ev;
      ev.func         = func;
      ev.packet_word  = word;
      ev.frame_kind   = kind;
      ev.frame_seq    = fseq;
      ev.frame_ack_no = fack;
      ev.crc_good     = good;
      return ev;
   endfunction

   task automatic push_cmd(input logic [2:0] act, input logic [2:0] seq,
                           input logic [2:0] ack, input logic [31:0] word,
                           input logic en, input logic fin);
      rsp_type r;
      r.action      = act;
      r.seq_out     = seq;
      r.ack_out     = ack;
      r.payload_out = word;
      r.net_enable  = en;
      r.last        = fin;
      pending_cmds.push_back(r);
   endtask

   // predicts the command run of one accepted event and updates the window
   task automatic window_engine_step(input req_type ev);
      int unsigned i;
      case (ev.func)
         FN_PACKET: begin
            if (tx_outstanding < SEQ_MAX) begin
               sent_words[tx_next] = ev.packet_word;
               tx_outstanding++;
               push_cmd(ACT_SEND_DATA, tx_next, seq_before(rx_expected),
                        ev.packet_word, 1'b0, 1'b0);
               tx_next = seq_after(tx_next);
            end else begin
               packets_dropped++;
            end
         end
         FN_PHY_RDY: begin
            phy_up = 1'b1;
         end
         FN_FRAME: begin
            if (ev.crc_good) begin
               if (ev.frame_kind == KIND_DATA && ev.frame_seq == rx_expected) begin
                  push_cmd(ACT_DELIVER, ev.frame_seq, 3'd0, ev.packet_word, 1'b0, 1'b0);
                  rx_expected = seq_after(rx_expected);
                  frames_delivered++;
               end
               if (ev.frame_ack_no <= SEQ_MAX) begin
                  while (tx_outstanding > 0 &&
                         ack_in_window(tx_oldest, ev.frame_ack_no, tx_next)) begin
                     tx_outstanding--;
                     push_cmd(ACT_STOP_TMR, tx_oldest, 3'd0, 32'd0, 1'b0, 1'b0);
                     tx_oldest = seq_after(tx_oldest);
                     frames_retired++;
                  end
               end
            end
         end
         FN_DATA_TMO: begin
            tx_next = tx_oldest;
            for (i = 0; i < tx_outstanding; i++) begin
               push_cmd(ACT_SEND_DATA, tx_next, seq_before(rx_expected),
                        sent_words[tx_next], 1'b0, 1'b0);
               tx_next = seq_after(tx_next);
               frames_resent++;
            end
         end
         FN_ACK_TMO: begin
            push_cmd(ACT_SEND_ACK, 3'd0, seq_before(rx_expected), 32'd0, 1'b0, 1'b0);
         end
         default: ;
      endcase
      push_cmd(ACT_STATUS, 3'd0, 3'd0, 32'd0,
               (tx_outstanding < SEQ_MAX) && phy_up, 1'b1);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch on result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_cmds.size() == 0) begin
         report_mismatch("unexpected item, action", 32'(got.action), 32'd0);
      end else begin
         want = pending_cmds.pop_front();
         if (got.action !== want.action)
            report_mismatch("action", 32'(got.action), 32'(want.action));
         if (got.seq_out !== want.seq_out)
            report_mismatch("seq_out", 32'(got.seq_out), 32'(want.seq_out));
         if (got.ack_out !== want.ack_out)
            report_mismatch("ack_out", 32'(got.ack_out), 32'(want.ack_out));
         if (got.payload_out !== want.payload_out)
            report_mismatch("payload_out", got.payload_out, want.payload_out);
         if (got.net_enable !== want.net_enable)
            report_mismatch("net_enable", 32'(got.net_enable), 32'(want.net_enable));
         if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
      end
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         check_result(rsp_if.payload);
   end

   // offers one event item and predicts its run once it is taken
   task automatic send_event(input req_type ev);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= ev;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      window_engine_step(ev);
      events_sent++;
   endtask

   task automatic test_idle_start;
      send_event(make_event(FN_ACK_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
      // packet taken while the physical layer is still down
      send_event(make_event(FN_PACKET, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
      send_event(make_event(FN_PHY_RDY, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
   endtask

   task automatic test_window_fill;
      send_event(make_event(FN_PACKET, 32'hffff_ffff, 1'b1, 3'd7, 3'd7, 1'b1));
      send_event(make_event(FN_PACKET, 32'haaaa_aaaa, 1'b0, 3'd0, 3'd0, 1'b0));
      send_event(make_event(FN_PACKET, 32'h5555_5555, 1'b1, 3'd5, 3'd2, 1'b1));
      send_event(make_event(FN_PACKET, 32'h0000_0001, 1'b0, 3'd2, 3'd5, 1'b0));
      send_event(make_event(FN_PACKET, 32'h8000_0000, 1'b0, 3'd0, 3'd0, 1'b0));
      send_event(make_event(FN_PACKET, 32'hdead_beef, 1'b0, 3'd0, 3'd0, 1'b0));
      // window now full, this one is dropped
      send_event(make_event(FN_PACKET, 32'h1234_5678, 1'b0, 3'd0, 3'd0, 1'b0));
   endtask

   task automatic test_retransmit;
      send_event(make_event(FN_DATA_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
   endtask

   task automatic test_frame_receive;
      // bad crc: would otherwise deliver and retire
      send_event(make_event(FN_FRAME, 32'h0bad_0bad, KIND_DATA, 3'd0, 3'd3, 1'b0));
      // out of order with an ack outside the window
      send_event(make_event(FN_FRAME, 32'h1111_1111, KIND_DATA, 3'd3, 3'd7, 1'b1));
      send_event(make_event(FN_FRAME, 32'hffff_ffff, KIND_DATA, 3'd0, 3'd2, 1'b1));
      send_event(make_event(FN_FRAME, 32'h0000_0000, ~KIND_DATA, 3'd1, 3'd6, 1'b1));
   endtask

   task automatic test_timers_and_unknown;
      send_event(make_event(FN_ACK_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
      // nothing outstanding, so only status
      send_event(make_event(FN_DATA_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
      send_event(make_event(3'd5, $urandom, 1'b1, 3'd7, 3'd7, 1'b1));
      send_event(make_event(3'd6, $urandom, 1'b0, 3'd1, 3'd0, 1'b1));
      send_event(make_event(3'd7, $urandom, 1'b1, 3'd0, 3'd1, 1'b0));
   endtask

   task automatic test_random_traffic;
      int unsigned counted;
      int unsigned sel;
      logic [2:0]  fseq;
      logic [2:0]  fack;
      logic        good;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         no_idle = (counted >= 60 && counted < 110);
         sel = $urandom_range(99);
         if (sel < 30) begin
            send_event(make_event(FN_PACKET, $urandom, 1'($urandom_range(1)),
                                  3'($urandom_range(7)), 3'($urandom_range(7)),
                                  1'($urandom_range(1))));
            counted++;
         end else if (sel < 34) begin
            send_event(make_event(FN_PHY_RDY, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
            counted++;
         end else if (sel < 74) begin
            fseq = ($urandom_range(4) != 0) ? rx_expected : 3'($urandom_range(7));
            if (tx_outstanding > 0 && $urandom_range(9) < 7)
               fack = 3'((tx_oldest + $urandom_range(tx_outstanding - 1)) % SEQ_SPAN);
            else
               fack = 3'($urandom_range(7));
            good = ($urandom_range(9) != 0);
            send_event(make_event(FN_FRAME, $urandom, ($urandom_range(3) == 0),
                                  fseq, fack, good));
            if (good)
               counted++;
         end else if (sel < 84) begin
            send_event(make_event(FN_DATA_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
            counted++;
         end else if (sel < 91) begin
            send_event(make_event(FN_ACK_TMO, 32'd0, 1'b0, 3'd0, 3'd0, 1'b0));
            counted++;
         end else if (sel < 95) begin
            send_event(make_event(3'($urandom_range(5, 7)), $urandom,
                                  1'($urandom_range(1)), 3'($urandom_range(7)),
                                  3'($urandom_range(7)), 1'($urandom_range(1))));
         end else begin
            // fully random fields
            send_event(make_event(3'($urandom_range(7)), $urandom,
                                  1'($urandom_range(1)), 3'($urandom_range(7)),
                                  3'($urandom_range(7)), 1'($urandom_range(1))));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.payload   = '0;
      tx_next          = 3'd0;
      tx_oldest        = 3'd0;
      rx_expected      = 3'd0;
      tx_outstanding   = 0;
      phy_up           = 1'b0;
      error_count      = 0;
      events_sent      = 0;
      results_checked  = 0;
      packets_dropped  = 0;
      frames_delivered = 0;
      frames_retired   = 0;
      frames_resent    = 0;
      no_idle          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_start;
      test_window_fill;
      test_retransmit;
      test_frame_receive;
      test_timers_and_unknown;
      test_random_traffic;

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      // catch any stray items after the last status
      repeat (SEQ_MAX + 8) @(posedge clock);

      $display("%0d events sent, %0d result items checked, %0d packets dropped",
               events_sent, results_checked, packets_dropped);
      $display("%0d frames delivered, %0d retired by acks, %0d resent on timeout",
               frames_delivered, frames_retired, frames_resent);
      if (error_count == 0) begin
         $display("go_back_n_link_window regression: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("go_back_n_link_window regression: fail");
      end
      $finish;
   end

endmodule
